// File: sv/sada_pkg.sv
// Shared types and codes for the sparse Adagrad dual-averaging update block.
package sada_pkg;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ROW   = 2'd1;
  localparam logic [1:0] ST_DENOM = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_LEARN_RATE = 3'd0;
  localparam logic [2:0] REG_L1         = 3'd1;
  localparam logic [2:0] REG_L2         = 3'd2;
  localparam logic [2:0] REG_STEP       = 3'd3;
  localparam logic [2:0] REG_ROWS       = 3'd4;
  localparam logic [2:0] REG_ROW_WIDTH  = 3'd5;

  // Address accumulator width: 15-bit row times 13-bit width plus column
  localparam int ACC_W   = 30;
  localparam int WIDTH_W = 13;

  // Step counter load values (steps minus one) of the square root and the shared divider
  localparam logic [5:0] SQRT_ITER = 6'd31;
  localparam logic [5:0] DIV48_ITER = 6'd47;
  localparam logic [5:0] DIV32_ITER = 6'd31;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_ERR_ROW,
    OP_ADDR,
    OP_ADDR_SUB,
    OP_READ,
    OP_SUMS,
    OP_SQ_ACC,
    OP_ERR_DEN,
    OP_RATE,
    OP_SQRT_STEP,
    OP_DIV1_INIT,
    OP_DIV_STEP,
    OP_DENOM,
    OP_DIV2_INIT,
    OP_DIV3_INIT,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic row_bad;
    logic addr_ge;
    logic rate_zero;
    logic denom_zero;
  } dp_sts_t;

endpackage

// File: sv/sada_ctrl.sv
// Controller state machine sequencing the update of one element.
module sada_ctrl
  import sada_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  dp_sts_t sts,
  output dp_cmd_t cmd,
  output logic    busy,
  output logic    done
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_MOD, S_SUMS, S_SQACC, S_RATE, S_SQRT,
    S_D1INIT, S_DIV1, S_DENOM, S_CHKDEN, S_DIV2, S_L1, S_DIV3, S_FINISH
  } state_t;

  state_t     state, state_next;
  logic [5:0] cnt, cnt_next;
  logic       done_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    done_next  = 1'b0;
    cmd.op     = OP_NONE;
    unique case (state)
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (sts.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.op     = OP_LOAD;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.row_bad) begin
          cmd.op     = OP_ERR_ROW;
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.op     = OP_ADDR;
          state_next = S_MOD;
        end
      end
      S_MOD: begin
        // wrap the address into the store depth, then read
        if (sts.addr_ge) begin
          cmd.op = OP_ADDR_SUB;
        end else begin
          cmd.op     = OP_READ;
          state_next = S_SUMS;
        end
      end
      S_SUMS: begin
        cmd.op     = OP_SUMS;
        state_next = S_SQACC;
      end
      S_SQACC: begin
        cmd.op     = OP_SQ_ACC;
        state_next = S_RATE;
      end
      S_RATE: begin
        if (sts.rate_zero) begin
          cmd.op     = OP_ERR_DEN;
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.op     = OP_RATE;
          cnt_next   = SQRT_ITER;
          state_next = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.op = OP_SQRT_STEP;
        if (cnt == '0) state_next = S_D1INIT;
        else cnt_next = cnt - 6'd1;
      end
      S_D1INIT: begin
        cmd.op     = OP_DIV1_INIT;
        cnt_next   = DIV48_ITER;
        state_next = S_DIV1;
      end
      S_DIV1: begin
        cmd.op = OP_DIV_STEP;
        if (cnt == '0) state_next = S_DENOM;
        else cnt_next = cnt - 6'd1;
      end
      S_DENOM: begin
        cmd.op     = OP_DENOM;
        state_next = S_CHKDEN;
      end
      S_CHKDEN: begin
        if (sts.denom_zero) begin
          cmd.op     = OP_ERR_DEN;
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.op     = OP_DIV2_INIT;
          cnt_next   = DIV32_ITER;
          state_next = S_DIV2;
        end
      end
      S_DIV2: begin
        cmd.op = OP_DIV_STEP;
        if (cnt == '0) state_next = S_L1;
        else cnt_next = cnt - 6'd1;
      end
      S_L1: begin
        cmd.op     = OP_DIV3_INIT;
        cnt_next   = DIV48_ITER;
        state_next = S_DIV3;
      end
      S_DIV3: begin
        cmd.op = OP_DIV_STEP;
        if (cnt == '0) state_next = S_FINISH;
        else cnt_next = cnt - 6'd1;
      end
      S_FINISH: begin
        cmd.op     = OP_FINISH;
        done_next  = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      done  <= done_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

// File: sv/sada_dp.sv
// Datapath: configuration registers, element stores, square root and divider.
module sada_dp
  import sada_pkg::*;
#(
  parameter int MAX_ROWS  = 1024,
  parameter int ROW_WIDTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_sts_t            sts,
  input  logic signed [15:0] row_index,
  input  logic [5:0]         column,
  input  logic signed [31:0] grad_value,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic signed [31:0] weight_value,
  output logic [1:0]         status
);

  localparam int DEPTH  = MAX_ROWS * ROW_WIDTH;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [ACC_W-1:0]   DEPTH_C = ACC_W'(DEPTH);
  localparam logic [ADDR_W-1:0]  LAST_C  = ADDR_W'(DEPTH - 1);
  localparam logic [16:0]        MAXR_C  = 17'(MAX_ROWS);
  localparam logic [WIDTH_W-1:0] RW_C    = WIDTH_W'(ROW_WIDTH);

  logic [30:0] learn_rate, l1_strength, l2_strength, step_count;
  logic [10:0] rows_in_use;
  logic [6:0]  row_width_in_use;

  logic [15:0] row_q;
  logic [5:0]  col_q;
  logic [31:0] g_q;

  logic [ACC_W-1:0]  addr_acc;
  logic [ADDR_W-1:0] clr_cnt;

  logic [31:0] sum_mem [DEPTH];
  logic [47:0] sq_mem  [DEPTH];
  logic [31:0] wt_mem  [DEPTH];
  logic [31:0] rd_sum;
  logic [47:0] rd_sq;

  logic [31:0] sum_q;
  logic [63:0] sqp_q;
  logic [47:0] sq_q;
  logic [61:0] rate_q;
  logic [63:0] sq_x, sq_r, sq_bit;
  logic [63:0] div_n, div_d, div_r, div_q;
  logic [48:0] denom_q;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate       <= 31'd65536;
      l1_strength      <= '0;
      l2_strength      <= '0;
      step_count       <= 31'd1;
      rows_in_use      <= 11'd1024;
      row_width_in_use <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEARN_RATE: learn_rate       <= cfg_data[30:0];
        REG_L1:         l1_strength      <= cfg_data[30:0];
        REG_L2:         l2_strength      <= cfg_data[30:0];
        REG_STEP:       step_count       <= cfg_data[30:0];
        REG_ROWS:       rows_in_use      <= cfg_data[10:0];
        REG_ROW_WIDTH:  row_width_in_use <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // combinational helpers
  logic [WIDTH_W-1:0] width_eff;
  logic [ADDR_W-1:0]  mem_addr;
  logic signed [32:0] sum_wide;
  logic [31:0]        sum_next, gmag, abs_sum, mag;
  logic [48:0]        sq_wide;
  logic [47:0]        sq_next;
  logic [63:0]        sq_t, rem2;
  logic [47:0]        quot;
  logic [31:0]        w_next;

  always_comb begin
    width_eff = ({6'd0, row_width_in_use} < RW_C) ? {6'd0, row_width_in_use} : RW_C;
    mem_addr  = (cmd.op == OP_CLEAR) ? clr_cnt : addr_acc[ADDR_W-1:0];

    sum_wide = $signed({rd_sum[31], rd_sum}) + $signed({g_q[31], g_q});
    if (sum_wide > 33'sd2147483647)       sum_next = 32'h7FFF_FFFF;
    else if (sum_wide < -33'sd2147483648) sum_next = 32'h8000_0000;
    else                                  sum_next = sum_wide[31:0];

    gmag    = g_q[31] ? (32'd0 - g_q) : g_q;
    sq_wide = {1'b0, rd_sq} + {1'b0, sqp_q[63:16]};
    sq_next = sq_wide[48] ? {48{1'b1}} : sq_wide[47:0];

    sq_t = sq_r + sq_bit;
    rem2 = {div_r[62:0], div_n[63]};

    abs_sum = sum_q[31] ? (32'd0 - sum_q) : sum_q;
    mag     = (div_q[31:0] > {1'b0, l1_strength}) ? (div_q[31:0] - {1'b0, l1_strength}) : '0;

    quot = div_q[47:0];
    if (!sum_q[31] && sum_q != '0)
      w_next = (quot > 48'h0_8000_0000) ? 32'h8000_0000 : (32'd0 - quot[31:0]);
    else if (sum_q[31])
      w_next = (quot > 48'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : quot[31:0];
    else
      w_next = '0;

    sts.clear_last = (clr_cnt == LAST_C);
    sts.row_bad    = row_q[15] || ({1'b0, row_q} >= {6'd0, rows_in_use})
                     || ({1'b0, row_q} >= MAXR_C);
    sts.addr_ge    = (addr_acc >= DEPTH_C);
    sts.rate_zero  = (step_count == '0) || (learn_rate == '0);
    sts.denom_zero = (denom_q == '0);
  end

  // stores: one write port each; the sum and square stores have one registered read each
  always_ff @(posedge clk) begin
    if (cmd.op == OP_CLEAR) sum_mem[mem_addr] <= '0;
    else if (cmd.op == OP_SUMS) sum_mem[mem_addr] <= sum_next;
    if (cmd.op == OP_READ) rd_sum <= sum_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_CLEAR) sq_mem[mem_addr] <= '0;
    else if (cmd.op == OP_SQ_ACC) sq_mem[mem_addr] <= sq_next;
    if (cmd.op == OP_READ) rd_sq <= sq_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_CLEAR || cmd.op == OP_ERR_DEN) wt_mem[mem_addr] <= '0;
    else if (cmd.op == OP_FINISH) wt_mem[mem_addr] <= w_next;
  end

  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (cmd.op == OP_CLEAR) clr_cnt <= clr_cnt + 1'b1;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        row_q <= row_index;
        col_q <= column;
        g_q   <= grad_value;
      end
      OP_ERR_ROW: begin
        weight_value <= '0;
        status       <= ST_ROW;
      end
      OP_ADDR:     addr_acc <= ACC_W'(row_q[14:0] * width_eff) + ACC_W'(col_q);
      OP_ADDR_SUB: addr_acc <= addr_acc - DEPTH_C;
      OP_SUMS: begin
        sum_q <= sum_next;
        sqp_q <= gmag * gmag;
      end
      OP_SQ_ACC:   sq_q <= sq_next;
      OP_ERR_DEN: begin
        weight_value <= '0;
        status       <= ST_DENOM;
      end
      OP_RATE: begin
        rate_q <= step_count * learn_rate;
        sq_x   <= {sq_q, 16'd0};
        sq_r   <= '0;
        sq_bit <= 64'h4000_0000_0000_0000;
      end
      OP_SQRT_STEP: begin
        if (sq_x >= sq_t) begin
          sq_x <= sq_x - sq_t;
          sq_r <= (sq_r >> 1) + sq_bit;
        end else begin
          sq_r <= sq_r >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
      OP_DIV1_INIT: begin
        div_n <= {sq_r[31:0], 32'd0};
        div_d <= {2'd0, rate_q};
        div_r <= '0;
        div_q <= '0;
      end
      OP_DIV_STEP: begin
        // one restoring quotient bit per beat
        if (rem2 >= div_d) begin
          div_r <= rem2 - div_d;
          div_q <= {div_q[62:0], 1'b1};
        end else begin
          div_r <= rem2;
          div_q <= {div_q[62:0], 1'b0};
        end
        div_n <= {div_n[62:0], 1'b0};
      end
      OP_DENOM: denom_q <= {18'd0, l2_strength} + {1'b0, div_q[47:0]};
      OP_DIV2_INIT: begin
        div_n <= {abs_sum, 32'd0};
        div_d <= {33'd0, step_count};
        div_r <= '0;
        div_q <= '0;
      end
      OP_DIV3_INIT: begin
        div_n <= {mag, 32'd0};
        div_d <= {15'd0, denom_q};
        div_r <= '0;
        div_q <= '0;
      end
      OP_FINISH: begin
        weight_value <= w_next;
        status       <= ST_OK;
      end
      default: ;
    endcase
  end

endmodule

// File: sv/sparse_adagrad_da_update_top.sv
// Top level of the sparse Adagrad dual-averaging update block.
// Usage:
//   Raise start with row_index, column and grad_value; the item is taken at
//   a clock edge where start is high and busy is low. One element is handled
//   at a time, and busy stays high until its result is out.
//   The result appears on weight_value and status for one cycle with done
//   high; the receiver cannot stall, so it must take the beat then.
//   An out-of-range row ends the update early. A full update runs a
//   32-step square root and three restoring divisions (48, 32 and 48 steps)
//   on one shared divider, plus one address subtraction per address wrap.
//   A zero rate or zero denominator ends the update early with status 2.
//   Configuration writes go through cfg_valid/cfg_index/cfg_data and are
//   always accepted (cfg_ready is tied high); write only while idle.
//   After reset all MAX_ROWS*ROW_WIDTH store entries are cleared, one entry a
//   cycle, with busy high; config writes are taken meanwhile.
module sparse_adagrad_da_update_top
  import sada_pkg::*;
#(
  parameter int MAX_ROWS  = 1024,
  parameter int ROW_WIDTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] row_index,
  input  logic [5:0]         column,
  input  logic signed [31:0] grad_value,
  output logic               done,
  output logic signed [31:0] weight_value,
  output logic [1:0]         status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  sada_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  sada_dp #(
    .MAX_ROWS  (MAX_ROWS),
    .ROW_WIDTH (ROW_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .row_index    (row_index),
    .column       (column),
    .grad_value   (grad_value),
    .cfg_we       (cfg_valid & cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .weight_value (weight_value),
    .status       (status)
  );

endmodule
